FILE: sv/gps_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the grouped packed store.
// No dependencies.
package gps_pkg;

	localparam int OUT_PAY_W = 64;
	localparam int POS_W     = 10;
	localparam int SIZE_W    = 11;
	localparam int GIU_W     = 6;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_BAD_GROUP = 2'd2,
		STAT_BAD_POS   = 2'd3
	} status_t;

	typedef struct packed {
		status_t               status;
		logic [OUT_PAY_W-1:0]  read_payload;
		logic [POS_W-1:0]      placed_position;
		logic [SIZE_W-1:0]     group_size;
		logic [SIZE_W-1:0]     stored_count;
	} result_t;

endpackage

FILE: sv/gps_start_mem.sv
`timescale 1ns / 1ps
// Group start offset table: synchronous memory with a registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
module gps_start_mem #(
	parameter int DEPTH = 33,
	parameter int AW    = 6,
	parameter int DW    = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata
);

	logic [DW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [DW-1:0]    rdata_s1;
	logic             rvld_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_s1 <= vld_q[raddr];
			end
		end
	end

	assign rdata = rvld_s1 ? rdata_s1 : '0;

endmodule

FILE: sv/gps_payload_mem.sv
`timescale 1ns / 1ps
// Packed payload store: single write port, single registered read port.
// No dependencies.
module gps_payload_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 64
) (
	input  logic          clk,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	assign rdata = rdata_s1;

endmodule

FILE: sv/grouped_packed_store_unit.sv
`timescale 1ns / 1ps
// Grouped packed store: top level with the operation sequencer.
// Uses gps_pkg, gps_start_mem and gps_payload_mem.
//
// Payload words sit packed in one memory, grouped contiguously by group
// number; a table of GROUPS+1 start offsets (the last equals the element
// count) marks the groups. One request is in flight at a time. An insert
// walks from the target group's end offset up through the last table entry,
// a remove first scans the table from entry 0 for the group holding the
// position and then walks to the last entry. Each walked entry takes a start
// table read, then an update, plus a payload read and a write back when an
// element moves; a scanned entry takes the table read and check only. The
// next request is taken in the cycle after the result is loaded. The start
// table and payload memory share no port, so the walk is paced by the
// registered read of each memory. The start table clears through per-entry
// valid bits, so no clearing pass runs after reset. The result register
// frees the input side: a new request is taken while the previous result
// still waits for out_ready.
module grouped_packed_store_unit #(
	parameter int CAPACITY     = 1024,
	parameter int GROUPS       = 32,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   operation,
	input  logic [4:0]                   group,
	input  logic [gps_pkg::POS_W-1:0]    position,
	input  logic [gps_pkg::OUT_PAY_W-1:0] payload,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic [gps_pkg::OUT_PAY_W-1:0] read_payload,
	output logic [gps_pkg::POS_W-1:0]    placed_position,
	output logic [gps_pkg::SIZE_W-1:0]   group_size,
	output logic [gps_pkg::SIZE_W-1:0]   stored_count,
	// groups_in_use register write
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [gps_pkg::GIU_W-1:0]    cfg_data
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // payload address
	localparam int CW = $clog2(CAPACITY + 1);                     // offsets, count
	localparam int GW = $clog2(GROUPS + 1);                       // table index
	localparam int PW = PAYLOAD_BITS;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WALK,   // issue start table read for entry j
		S_CHK,    // table data back: update entry, maybe start a move
		S_MOVE,   // payload data back: write it to its new slot
		S_PREAD,  // read op: issue payload read
		S_PDATA,  // read op: payload back
		S_QLO,    // query: read group start
		S_QHI,    // query: read next group start
		S_QEND,   // query: size
		S_DONE    // result waits for the output register
	} state_t;

	state_t                  state_q;
	gps_pkg::op_t            op_q;
	logic [GW-1:0]           g_q;
	logic [GW-1:0]           j_q;
	logic [gps_pkg::POS_W-1:0] pos_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           off_q;     // slot being read for a move
	logic [CW-1:0]           link_q;    // insert: previous slot; remove: hole
	logic [PW-1:0]           carry_q;   // insert: word being pushed forward
	logic                    first_q;   // insert: first walked entry
	logic                    search_q;  // remove: still looking for the group
	logic [CW-1:0]           qstart_q;
	logic [gps_pkg::GIU_W-1:0] giu_q;
	gps_pkg::result_t        res_q;
	gps_pkg::result_t        out_q;
	logic                    out_valid_q;

	// memory ports
	logic          sm_re, sm_we;
	logic [GW-1:0] sm_raddr, sm_waddr;
	logic [CW-1:0] sm_rdata, sm_wdata;
	logic          pm_re, pm_we;
	logic [AW-1:0] pm_raddr, pm_waddr;
	logic [PW-1:0] pm_rdata, pm_wdata;

	gps_start_mem #(.DEPTH(GROUPS + 1), .AW(GW), .DW(CW)) u_start (
		.clk(clk), .arst_n(arst_n),
		.re(sm_re), .raddr(sm_raddr), .rdata(sm_rdata),
		.we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata)
	);

	gps_payload_mem #(.DEPTH(CAPACITY), .AW(AW), .DW(PW)) u_payload (
		.clk(clk),
		.re(pm_re), .raddr(pm_raddr), .rdata(pm_rdata),
		.we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata)
	);

	// request decode
	logic        in_acc;
	logic [31:0] giu_lim;
	logic        grp_ok;
	logic        pos_ok;
	logic        full;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign giu_lim   = (32'(giu_q) > GROUPS) ? 32'(GROUPS) : 32'(giu_q);
	assign grp_ok    = 32'(group) < giu_lim;
	assign pos_ok    = 32'(position) < 32'(count_q);
	assign full      = 32'(count_q) >= CAPACITY;

	// walk step decode, valid in S_CHK
	logic [CW-1:0] raw;
	logic [CW-1:0] newv;
	logic          is_ins;
	logic          scan_on;
	logic          do_move;
	logic [CW-1:0] move_src;
	logic          last_entry;

	assign raw        = sm_rdata;
	assign is_ins     = (op_q == gps_pkg::OP_INSERT);
	assign newv       = is_ins ? raw + CW'(1) : raw - CW'(1);
	assign scan_on    = search_q && (32'(j_q) < GROUPS) && (32'(raw) <= 32'(pos_q));
	assign move_src   = is_ins ? raw : newv;
	assign do_move    = is_ins ? (first_q || (raw != link_q && 32'(raw) < CAPACITY))
	                           : (newv != link_q && 32'(newv) < CAPACITY);
	assign last_entry = (32'(j_q) == GROUPS);

	always_comb begin
		sm_re    = 1'b0;
		sm_raddr = j_q;
		sm_we    = 1'b0;
		sm_waddr = j_q;
		sm_wdata = newv;
		pm_re    = 1'b0;
		pm_raddr = AW'(move_src);
		pm_we    = 1'b0;
		pm_waddr = AW'(off_q);
		pm_wdata = carry_q;
		unique case (state_q)
			S_WALK: begin
				sm_re = 1'b1;
			end
			S_CHK: begin
				if (!scan_on) begin
					sm_we = 1'b1;
					pm_re = do_move;
				end
			end
			S_MOVE: begin
				pm_we = 1'b1;
				if (!is_ins) begin
					pm_waddr = AW'(link_q);
					pm_wdata = pm_rdata;
				end
			end
			S_PREAD: begin
				pm_re    = 1'b1;
				pm_raddr = AW'(pos_q);
			end
			S_QLO: begin
				sm_re    = 1'b1;
				sm_raddr = g_q;
			end
			S_QHI: begin
				sm_re    = 1'b1;
				sm_raddr = g_q + GW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			giu_q       <= gps_pkg::GIU_W'(1);
			out_valid_q <= 1'b0;
			op_q        <= gps_pkg::OP_INSERT;
			g_q         <= '0;
			j_q         <= '0;
			pos_q       <= '0;
			off_q       <= '0;
			link_q      <= '0;
			carry_q     <= '0;
			first_q     <= 1'b0;
			search_q    <= 1'b0;
			qstart_q    <= '0;
			res_q       <= '0;
			out_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				giu_q <= cfg_data;
			end
			// output register: load a finished result, or drop the one taken
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q     <= gps_pkg::op_t'(operation);
						g_q      <= GW'(group);
						pos_q    <= position;
						first_q  <= 1'b1;
						carry_q  <= payload[PW-1:0];
						unique case (gps_pkg::op_t'(operation))
							gps_pkg::OP_INSERT: begin
								if (!grp_ok) begin
									res_q.status <= gps_pkg::STAT_BAD_GROUP;
									state_q      <= S_DONE;
								end else if (full) begin
									res_q.status <= gps_pkg::STAT_FULL;
									state_q      <= S_DONE;
								end else begin
									j_q      <= GW'(group) + GW'(1);
									search_q <= 1'b0;
									state_q  <= S_WALK;
								end
							end
							gps_pkg::OP_REMOVE: begin
								if (!pos_ok) begin
									res_q.status <= gps_pkg::STAT_BAD_POS;
									state_q      <= S_DONE;
								end else begin
									j_q      <= '0;
									link_q   <= CW'(position);
									search_q <= 1'b1;
									state_q  <= S_WALK;
								end
							end
							gps_pkg::OP_READ: begin
								if (!pos_ok) begin
									res_q.status <= gps_pkg::STAT_BAD_POS;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_PREAD;
								end
							end
							gps_pkg::OP_QUERY: begin
								if (!grp_ok) begin
									res_q.status <= gps_pkg::STAT_BAD_GROUP;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_QLO;
								end
							end
						endcase
					end
				end
				S_WALK: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (scan_on) begin
						j_q     <= j_q + GW'(1);
						state_q <= S_WALK;
					end else begin
						search_q <= 1'b0;
						off_q    <= move_src;
						if (is_ins && first_q) begin
							res_q.placed_position <= gps_pkg::POS_W'(raw);
						end
						if (do_move) begin
							state_q <= S_MOVE;
						end else if (last_entry) begin
							count_q <= is_ins ? count_q + CW'(1) : count_q - CW'(1);
							state_q <= S_DONE;
						end else begin
							j_q     <= j_q + GW'(1);
							state_q <= S_WALK;
						end
					end
				end
				S_MOVE: begin
					if (is_ins) begin
						carry_q <= pm_rdata;
					end
					link_q  <= off_q;
					first_q <= 1'b0;
					if (last_entry) begin
						count_q <= is_ins ? count_q + CW'(1) : count_q - CW'(1);
						state_q <= S_DONE;
					end else begin
						j_q     <= j_q + GW'(1);
						state_q <= S_WALK;
					end
				end
				S_PREAD: begin
					state_q <= S_PDATA;
				end
				S_PDATA: begin
					res_q.read_payload <= gps_pkg::OUT_PAY_W'(pm_rdata);
					state_q            <= S_DONE;
				end
				S_QLO: begin
					state_q <= S_QHI;
				end
				S_QHI: begin
					qstart_q <= sm_rdata;
					state_q  <= S_QEND;
				end
				S_QEND: begin
					res_q.placed_position <= gps_pkg::POS_W'(qstart_q);
					res_q.group_size      <= gps_pkg::SIZE_W'(sm_rdata - qstart_q);
					state_q               <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q <= '{
							status:          res_q.status,
							read_payload:    res_q.read_payload,
							placed_position: res_q.placed_position,
							group_size:      res_q.group_size,
							stored_count:    gps_pkg::SIZE_W'(count_q)
						};
						res_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign read_payload    = out_q.read_payload;
	assign placed_position = out_q.placed_position;
	assign group_size      = out_q.group_size;
	assign stored_count    = out_q.stored_count;

	// count never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= CAPACITY)
		else $error("element count above capacity");

	// count moves by at most one per cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1))
			|| (count_q == $past(count_q) - CW'(1)))
		else $error("element count jumped");

	// a payload move always follows a table update
	a_move_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE) |-> ($past(state_q) == S_CHK))
		else $error("payload move without table update");

endmodule
